// ----- rtl/egcd_pkg.sv -----
// Package for the extended GCD block: field widths, request and response
// structs, and controller to datapath command and status structs.
// No dependencies.
`default_nettype none

package egcd_pkg;

   localparam int OPND_WIDTH_DEF = 31;  // default operand width
   localparam int IN_WIDTH       = 31;  // operand field width on the port
   localparam int GCD_WIDTH      = 31;
   localparam int COEF_WIDTH     = 32;

   typedef struct packed {
      logic [IN_WIDTH-1:0] first_operand;
      logic [IN_WIDTH-1:0] second_operand;
   } egcd_req_type;

   typedef struct packed {
      logic [GCD_WIDTH-1:0]         gcd_value;
      logic signed [COEF_WIDTH-1:0] coef_larger;
      logic signed [COEF_WIDTH-1:0] coef_smaller;
      logic                         operands_swapped;
   } egcd_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture and order the operands
      logic div_init;  // clear remainder and products, load dividend
      logic div_step;  // one restoring division bit
      logic update;    // advance remainders and coefficients
   } egcd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rcur_zero;  // current remainder is zero
   } egcd_sts_type;

endpackage

`default_nettype wire

// ----- rtl/egcd_ctrl.sv -----
// Controller state machine for the extended GCD block.
// Depends on egcd_pkg.
`default_nettype none

module egcd_ctrl #(
   parameter int OPERAND_WIDTH = egcd_pkg::OPND_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_strobe,
   input  wire egcd_pkg::egcd_sts_type sts,
   output egcd_pkg::egcd_cmd_type     cmd
);

   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE
   } state_type;

   state_type             state_ff;
   logic                  busy_ff;
   logic                  strobe_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  accept;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.div_init = (state_ff == ST_CHECK) && !sts.rcur_zero;
      cmd.div_step = (state_ff == ST_DIV);
      cmd.update   = (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CHECK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_CHECK: begin
               if (sts.rcur_zero) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= ST_DIV;
                  cnt_ff   <= '0;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_CHECK;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("response strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after request accepted");

   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy_ff)
      else $error("response strobe while busy");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (busy_ff && !strobe_ff))
      else $error("division running outside a request");
`endif

endmodule

`default_nettype wire

// ----- rtl/egcd_dpath.sv -----
// Datapath for the extended GCD block: remainder pair, coefficient pairs,
// radix-2 restoring divider and shift-add quotient products. Depends on egcd_pkg.
`default_nettype none

module egcd_dpath #(
   parameter int OPERAND_WIDTH = egcd_pkg::OPND_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire egcd_pkg::egcd_req_type  req_data,
   input  wire egcd_pkg::egcd_cmd_type  cmd,
   output egcd_pkg::egcd_sts_type      sts,
   output egcd_pkg::egcd_rsp_type      rsp_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int CW = egcd_pkg::COEF_WIDTH;

   logic [W-1:0]  r_prev_ff, r_cur_ff;
   logic [CW-1:0] s_prev_ff, s_cur_ff, t_prev_ff, t_cur_ff;
   logic          swapped_ff;

   logic [W-1:0]  rem_ff, dvd_ff;
   logic [CW-1:0] acc_s_ff, acc_t_ff;

   logic [W-1:0]  opnd_a, opnd_b;
   logic [W:0]    rem_sh;
   logic          q_bit;
   logic [W-1:0]  rem_in;
   logic [CW-1:0] acc_s_in, acc_t_in;

   assign opnd_a = W'(req_data.first_operand);
   assign opnd_b = W'(req_data.second_operand);

   // one restoring division step
   assign rem_sh   = {rem_ff, dvd_ff[W-1]};
   assign q_bit    = (rem_sh >= {1'b0, r_cur_ff});
   assign rem_in   = q_bit ? W'(rem_sh - {1'b0, r_cur_ff}) : rem_sh[W-1:0];
   // quotient times coefficient, built MSB first, modulo 2^32
   assign acc_s_in = {acc_s_ff[CW-2:0], 1'b0} + (q_bit ? s_cur_ff : '0);
   assign acc_t_in = {acc_t_ff[CW-2:0], 1'b0} + (q_bit ? t_cur_ff : '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (opnd_a < opnd_b) begin
            r_prev_ff  <= opnd_b;
            r_cur_ff   <= opnd_a;
            swapped_ff <= 1'b1;
         end else begin
            r_prev_ff  <= opnd_a;
            r_cur_ff   <= opnd_b;
            swapped_ff <= 1'b0;
         end
         s_prev_ff <= CW'(1);
         s_cur_ff  <= '0;
         t_prev_ff <= '0;
         t_cur_ff  <= CW'(1);
      end else if (cmd.update) begin
         r_prev_ff <= r_cur_ff;
         r_cur_ff  <= rem_ff;
         s_prev_ff <= s_cur_ff;
         s_cur_ff  <= s_prev_ff - acc_s_ff;
         t_prev_ff <= t_cur_ff;
         t_cur_ff  <= t_prev_ff - acc_t_ff;
      end

      if (cmd.div_init) begin
         rem_ff   <= '0;
         dvd_ff   <= r_prev_ff;
         acc_s_ff <= '0;
         acc_t_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         dvd_ff   <= {dvd_ff[W-2:0], 1'b0};
         acc_s_ff <= acc_s_in;
         acc_t_ff <= acc_t_in;
      end
   end

   assign sts.rcur_zero = (r_cur_ff == '0);

   assign rsp_data.gcd_value        = egcd_pkg::GCD_WIDTH'(r_prev_ff);
   assign rsp_data.coef_larger      = s_prev_ff;
   assign rsp_data.coef_smaller     = t_prev_ff;
   assign rsp_data.operands_swapped = swapped_ff;

endmodule

`default_nettype wire

// ----- rtl/extended_gcd_bezout.sv -----
// Top level of the extended GCD block: controller and datapath.
// Depends on egcd_pkg, egcd_ctrl and egcd_dpath.
//
// Usage
//   Request: drive req_data and raise start; the request is taken at a
//   rising edge where start is high and busy is low. Operands are masked or
//   zero-extended to OPERAND_WIDTH and ordered larger first.
//   Response: rsp_data is valid for the single cycle in which rsp_strobe is
//   high; the receiver must take it then, it cannot stall the block.
// Operation
//   One request at a time. With k Euclid iterations the strobe follows
//   acceptance after k iterations and a final remainder test: each iteration
//   is a remainder test, OPERAND_WIDTH steps of the radix-2 divider and an
//   update. At 31 bits k is at most 44 (consecutive Fibonacci operands).
//   busy falls with the strobe, so the next request may be taken in the
//   strobe cycle itself.
// Reset
//   Synchronous, active high; returns the controller to idle with busy and
//   rsp_strobe low. Datapath registers are not reset.
`default_nettype none

module extended_gcd_bezout #(
   parameter int OPERAND_WIDTH = egcd_pkg::OPND_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire egcd_pkg::egcd_req_type  req_data,
   output logic                        rsp_strobe,
   output egcd_pkg::egcd_rsp_type      rsp_data
);

   // command and status between controller and datapath
   egcd_pkg::egcd_cmd_type cmd;
   egcd_pkg::egcd_sts_type sts;

   egcd_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .sts        (sts),
      .cmd        (cmd)
   );

   // response fields sit in datapath registers, stable while idle
   egcd_dpath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
